/* rtl/psitt_pkg.sv */
`default_nettype none

package psitt_pkg;

  localparam int unsigned LenW           = 13;
  localparam int unsigned DataW          = 32;
  localparam int unsigned AddrW          = 4;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned MaxSectionsDef = 64;

  localparam logic [LenW-1:0] HdrFixedBytes = 13'd3;

  localparam logic [7:0]      ExpectedTableRst = 8'd64;
  localparam logic [LenW-1:0] MinHeaderRst     = 13'd8;
  localparam logic [LenW-1:0] MaxSectionRst    = 13'd4096;
  localparam logic [7:0]      ReadLimitRst     = 8'd8;

  typedef enum logic [1:0] {
    REG_EXPECTED_TABLE = 2'd0,
    REG_MIN_HEADER     = 2'd1,
    REG_MAX_SECTION    = 2'd2,
    REG_READ_LIMIT     = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_STORED      = 3'd0,
    ST_SHORT       = 3'd1,
    ST_BAD_LEN     = 3'd2,
    ST_WRONG_TABLE = 3'd3,
    ST_NOT_CURRENT = 3'd4,
    ST_BAD_NUMBER  = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0]      expected_table;
    logic [LenW-1:0] min_header_bytes;
    logic [LenW-1:0] max_section_bytes;
    logic [7:0]      read_attempt_limit;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  tid;
    logic [15:0] extension;
    logic [4:0]  version;
    logic [7:0]  sec_index;
    logic [7:0]  last_index;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/psitt_if.sv */
`default_nettype none

interface psitt_in_if import psitt_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [7:0]      hdr_table_id;
  logic [7:0]      hdr_length_hi;
  logic [7:0]      hdr_length_lo;
  logic [7:0]      hdr_ext_hi;
  logic [7:0]      hdr_ext_lo;
  logic [7:0]      hdr_version_byte;
  logic [7:0]      hdr_section_index;
  logic [7:0]      hdr_last_index;
  logic [LenW-1:0] received_bytes;

  modport source (
    output valid, hdr_table_id, hdr_length_hi, hdr_length_lo, hdr_ext_hi, hdr_ext_lo,
           hdr_version_byte, hdr_section_index, hdr_last_index, received_bytes,
    input  ready
  );
  modport sink (
    input  valid, hdr_table_id, hdr_length_hi, hdr_length_lo, hdr_ext_hi, hdr_ext_lo,
           hdr_version_byte, hdr_section_index, hdr_last_index, received_bytes,
    output ready
  );
endinterface

interface psitt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       table_was_reset;
  logic       table_complete;
  logic [7:0] read_budget;

  modport source (
    output valid, status, table_was_reset, table_complete, read_budget,
    input  ready
  );
  modport sink (
    input  valid, status, table_was_reset, table_complete, read_budget,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/psitt_front.sv */
`default_nettype none

module psitt_front import psitt_pkg::*; #(
  parameter int unsigned MAX_SECTIONS = MaxSectionsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cfg_t   cfg_i,
  psitt_in_if.sink    in_i,
  output logic        push_valid_o,
  input  wire logic   push_ready_i,
  output entry_t      push_data_o
);

  logic            stage_valid_q;
  entry_t          stage_q;
  entry_t          stage_d;
  logic [LenW-1:0] total;
  logic            accept;

  assign in_i.ready = !stage_valid_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  assign total = HdrFixedBytes + {1'b0, in_i.hdr_length_hi[3:0], in_i.hdr_length_lo};

  always_comb begin
    stage_d.tid        = in_i.hdr_table_id;
    stage_d.extension  = {in_i.hdr_ext_hi, in_i.hdr_ext_lo};
    stage_d.version    = in_i.hdr_version_byte[5:1];
    stage_d.sec_index  = in_i.hdr_section_index;
    stage_d.last_index = in_i.hdr_last_index;
    priority if (in_i.received_bytes < cfg_i.min_header_bytes) begin
      stage_d.status = ST_SHORT;
    end else if (total > in_i.received_bytes || total > cfg_i.max_section_bytes) begin
      stage_d.status = ST_BAD_LEN;
    end else if (in_i.hdr_table_id != cfg_i.expected_table) begin
      stage_d.status = ST_WRONG_TABLE;
    end else if (!in_i.hdr_version_byte[0]) begin
      stage_d.status = ST_NOT_CURRENT;
    end else if (in_i.hdr_section_index > in_i.hdr_last_index ||
                 32'(in_i.hdr_last_index) >= MAX_SECTIONS) begin
      stage_d.status = ST_BAD_NUMBER;
    end else begin
      stage_d.status = ST_STORED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (accept) begin
      stage_valid_q <= 1'b1;
    end else if (push_ready_i) begin
      stage_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
  end

  assign push_valid_o = stage_valid_q;
  assign push_data_o  = stage_q;

endmodule

`default_nettype wire

/* rtl/psitt_queue.sv */
`default_nettype none

module psitt_queue import psitt_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_valid_i,
  output logic        push_ready_o,
  input  wire entry_t push_data_i,
  output logic        pop_valid_o,
  input  wire logic   pop_ready_i,
  output entry_t      pop_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push;
  logic            pop;

  assign push_ready_o = cnt_q != CntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/psitt_back.sv */
`default_nettype none

module psitt_back import psitt_pkg::*; #(
  parameter int unsigned MAX_SECTIONS = MaxSectionsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cfg_t   cfg_i,
  input  wire logic   q_valid_i,
  output logic        q_ready_o,
  input  wire entry_t q_data_i,
  psitt_out_if.source out_o
);

  localparam int unsigned IdxW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SECTIONS + 1);

  logic                    cache_valid_q;
  logic [7:0]              cached_table_q;
  logic [15:0]             cached_ext_q;
  logic [4:0]              cached_ver_q;
  logic [7:0]              cached_last_q;
  logic [MAX_SECTIONS-1:0] map_q;
  logic [CntW-1:0]         cnt_q;
  logic                    complete_q;

  logic                    out_valid_q;
  logic [2:0]              out_status_q;
  logic                    out_reset_q;
  logic                    out_complete_q;
  logic [7:0]              out_budget_q;

  logic                    pop;
  logic                    store;
  logic                    id_change;
  logic [IdxW-1:0]         idx;
  logic [MAX_SECTIONS-1:0] map_base;
  logic [MAX_SECTIONS-1:0] map_next;
  logic [CntW-1:0]         cnt_base;
  logic [CntW-1:0]         cnt_next;
  logic                    complete_next;
  logic                    valid_n;
  logic [7:0]              last_n;
  logic                    complete_n;
  logic [7:0]              lim;
  logic [8:0]              n_sec;
  logic [7:0]              budget;

  assign q_ready_o = !out_valid_q || out_o.ready;
  assign pop       = q_valid_i && q_ready_o;
  assign store     = q_data_i.status == ST_STORED;
  assign idx       = q_data_i.sec_index[IdxW-1:0];

  assign id_change = !cache_valid_q || cached_table_q != q_data_i.tid ||
                     cached_ext_q != q_data_i.extension ||
                     cached_ver_q != q_data_i.version ||
                     cached_last_q != q_data_i.last_index;

  always_comb begin
    map_base      = id_change ? '0 : map_q;
    cnt_base      = id_change ? '0 : cnt_q;
    map_next      = map_base;
    map_next[idx] = 1'b1;
    cnt_next      = cnt_base + CntW'(!map_base[idx]);
    complete_next = ({1'b0, q_data_i.last_index} + 9'd1) == 9'(cnt_next);
    valid_n       = store ? 1'b1 : cache_valid_q;
    last_n        = store ? q_data_i.last_index : cached_last_q;
    complete_n    = store ? complete_next : complete_q;
    lim           = (cfg_i.read_attempt_limit == 8'd0) ? 8'd1 : cfg_i.read_attempt_limit;
    n_sec         = valid_n ? ({1'b0, last_n} + 9'd1) : 9'd1;
    budget        = (n_sec > {1'b0, lim}) ? lim : n_sec[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_valid_q  <= 1'b0;
      cached_table_q <= '0;
      cached_ext_q   <= '0;
      cached_ver_q   <= '0;
      cached_last_q  <= '0;
      map_q          <= '0;
      cnt_q          <= '0;
      complete_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (pop && store) begin
        cache_valid_q  <= 1'b1;
        cached_table_q <= q_data_i.tid;
        cached_ext_q   <= q_data_i.extension;
        cached_ver_q   <= q_data_i.version;
        cached_last_q  <= q_data_i.last_index;
        map_q          <= map_next;
        cnt_q          <= cnt_next;
        complete_q     <= complete_next;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_status_q   <= q_data_i.status;
      out_reset_q    <= store && id_change;
      out_complete_q <= valid_n && complete_n;
      out_budget_q   <= budget;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.table_was_reset = out_reset_q;
  assign out_o.table_complete  = out_complete_q;
  assign out_o.read_budget     = out_budget_q;

  a_cnt_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CntW'($countones(map_q)))
    else $error("section count disagrees with received map");

  a_complete_needs_cache: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete_q |-> cache_valid_q)
    else $error("table complete without a valid cache");

  a_stored_bit_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && store) |=> map_q[$past(idx)])
    else $error("stored section not marked as received");

  a_budget_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_budget_q != 8'd0))
    else $error("read budget of zero reported");

endmodule

`default_nettype wire

/* rtl/psi_section_table_tracker.sv */
// PSI section table tracker.
// The in_i channel takes one word per CRC-checked section: its eight header
// bytes and the received byte count. The out_o channel returns one word per
// section with a status code, the table reset flag, the completion flag and
// the read budget. Both channels move a word when valid and ready are high.
// A section passes from acceptance to the result word through the header
// check register, the two-entry queue and the output register, in that order.
// One word per cycle is sustained while the receiver holds out_o.ready high;
// the back end updates the received-section map as each section is stored.
// The APB port holds the expected table id, the minimum and maximum byte
// counts and the read attempt limit at byte addresses 0, 4, 8 and 12. The user
// must write it only while no section is in flight; the block does not enforce this.
// Reset clears the table identity, the received map and the completion flag
// and loads the register defaults. When the receiver stalls, the result word
// holds in the output register, the queue fills, and in_i.ready drops once
// every stage is occupied.
`default_nettype none

module psi_section_table_tracker import psitt_pkg::*; #(
  parameter int unsigned MAX_SECTIONS = MaxSectionsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  psitt_in_if.sink              in_i,
  psitt_out_if.source           out_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     q_push_valid;
  logic     q_push_ready;
  entry_t   q_push_data;
  logic     q_pop_valid;
  logic     q_pop_ready;
  entry_t   q_pop_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_table     <= ExpectedTableRst;
      cfg_q.min_header_bytes   <= MinHeaderRst;
      cfg_q.max_section_bytes  <= MaxSectionRst;
      cfg_q.read_attempt_limit <= ReadLimitRst;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_EXPECTED_TABLE: cfg_q.expected_table     <= pwdata[7:0];
        REG_MIN_HEADER:     cfg_q.min_header_bytes   <= pwdata[LenW-1:0];
        REG_MAX_SECTION:    cfg_q.max_section_bytes  <= pwdata[LenW-1:0];
        REG_READ_LIMIT:     cfg_q.read_attempt_limit <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EXPECTED_TABLE: prdata = DataW'(cfg_q.expected_table);
      REG_MIN_HEADER:     prdata = DataW'(cfg_q.min_header_bytes);
      REG_MAX_SECTION:    prdata = DataW'(cfg_q.max_section_bytes);
      REG_READ_LIMIT:     prdata = DataW'(cfg_q.read_attempt_limit);
    endcase
  end

  psitt_front #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .push_valid_o(q_push_valid),
    .push_ready_i(q_push_ready),
    .push_data_o (q_push_data)
  );

  psitt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(q_push_valid),
    .push_ready_o(q_push_ready),
    .push_data_i (q_push_data),
    .pop_valid_o (q_pop_valid),
    .pop_ready_i (q_pop_ready),
    .pop_data_o  (q_pop_data)
  );

  psitt_back #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_valid_i(q_pop_valid),
    .q_ready_o(q_pop_ready),
    .q_data_i (q_pop_data),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import psitt_pkg::*;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned MaxSections   = MaxSectionsDef;
  localparam int unsigned MapIdxW       = (MaxSections > 1) ? $clog2(MaxSections) : 1;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned PhaseSections = 107;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned WatchdogLimit = 5000;

  typedef struct packed {
    logic [7:0]      tid;
    logic [7:0]      len_hi;
    logic [7:0]      len_lo;
    logic [7:0]      ext_hi;
    logic [7:0]      ext_lo;
    logic [7:0]      ver_byte;
    logic [7:0]      sec_idx;
    logic [7:0]      last_idx;
    logic [LenW-1:0] rx_bytes;
  } section_t;

  localparam int unsigned SectionW = $bits(section_t);

  typedef struct packed {
    status_e    status;
    logic       was_reset;
    logic       complete;
    logic [7:0] budget;
  } verdict_t;

  typedef struct packed {
    section_t hdr;
    logic     typed;
    verdict_t verdict;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  psitt_in_if  in_if ();
  psitt_out_if out_if ();

  psi_section_table_tracker dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Register shadow and the tracked table as the block should hold them.
  cfg_t                   regs = {ExpectedTableRst, MinHeaderRst, MaxSectionRst, ReadLimitRst};
  logic                   tbl_valid    = 1'b0;
  logic [7:0]             tbl_id       = '0;
  logic [15:0]            tbl_ext      = '0;
  logic [4:0]             tbl_ver      = '0;
  logic [7:0]             tbl_last     = '0;
  logic [MaxSections-1:0] tbl_map      = '0;
  logic                   tbl_complete = 1'b0;

  verdict_t    pending_verdicts[$];
  logic        drv_typed;
  verdict_t    drv_verdict;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles = 0;
  int unsigned words_in     = 0;
  int unsigned words_out    = 0;
  int unsigned stored_cnt   = 0;
  int unsigned resets_cnt   = 0;
  int unsigned complete_cnt = 0;
  int unsigned mismatch_cnt = 0;

  // Identity of the table the random sections belong to.
  logic [15:0] g_ext  = '0;
  logic [4:0]  g_ver  = '0;
  logic [7:0]  g_last = '0;
  logic [7:0]  g_next = '0;

  function automatic verdict_t track_section(section_t s);
    logic [LenW-1:0] total;
    logic [15:0]     ext;
    logic [7:0]      lim;
    logic [7:0]      span;
    logic            all_in;
    int              i;
    verdict_t        v;
    total = HdrFixedBytes + LenW'({s.len_hi[3:0], s.len_lo});
    ext   = {s.ext_hi, s.ext_lo};
    v     = '0;
    if (s.rx_bytes < regs.min_header_bytes) begin
      v.status = ST_SHORT;
    end else if (total > s.rx_bytes || total > regs.max_section_bytes) begin
      v.status = ST_BAD_LEN;
    end else if (s.tid != regs.expected_table) begin
      v.status = ST_WRONG_TABLE;
    end else if (!s.ver_byte[0]) begin
      v.status = ST_NOT_CURRENT;
    end else if (s.sec_idx > s.last_idx || s.last_idx >= MaxSections) begin
      v.status = ST_BAD_NUMBER;
    end else begin
      v.status = ST_STORED;
      if (!tbl_valid || tbl_id != s.tid || tbl_ext != ext ||
          tbl_ver != s.ver_byte[5:1] || tbl_last != s.last_idx) begin
        tbl_map     = '0;
        tbl_valid   = 1'b1;
        tbl_id      = s.tid;
        tbl_ext     = ext;
        tbl_ver     = s.ver_byte[5:1];
        tbl_last    = s.last_idx;
        v.was_reset = 1'b1;
      end
      tbl_map[s.sec_idx[MapIdxW-1:0]] = 1'b1;
      all_in = 1'b1;
      for (i = 0; i <= tbl_last; i++) all_in &= tbl_map[i];
      tbl_complete = all_in;
    end
    lim        = (regs.read_attempt_limit == 0) ? 8'd1 : regs.read_attempt_limit;
    span       = tbl_valid ? tbl_last + 8'd1 : 8'd1;
    v.budget   = (span > lim) ? lim : span;
    v.complete = tbl_valid && tbl_complete;
    return v;
  endfunction

  function automatic void pick_table_identity();
    int unsigned r;
    if ($urandom_range(1)) g_ext = 16'($urandom());
    if ($urandom_range(1)) g_ver = 5'($urandom());
    r = $urandom_range(99);
    g_last = 8'((r < 80) ? $urandom_range(7) : (r < 95) ? $urandom_range(MaxSections - 1)
                                                        : MaxSections - 1);
    g_next = '0;
  endfunction

  // Mostly sections of the current table, some with one check broken, some noise.
  function automatic section_t random_section();
    section_t    s;
    int unsigned pick;
    int unsigned len_max;
    int unsigned total;
    int unsigned lo;
    int unsigned hi;
    logic [11:0] len;
    pick = $urandom_range(99);
    if (pick < 85) begin
      if ($urandom_range(99) < 4) pick_table_identity();
      len_max = regs.max_section_bytes - 3;
      if (len_max > 4095) len_max = 4095;
      len = 12'(($urandom_range(99) < 70 && len_max > 300) ? $urandom_range(300)
                                                           : $urandom_range(len_max));
      total = len + 3;
      lo = (total > regs.min_header_bytes) ? total : regs.min_header_bytes;
      hi = ($urandom_range(99) < 80 && lo + 50 < 4098) ? lo + 50 : 4098;
      s.rx_bytes        = LenW'($urandom_range(hi, lo));
      s.tid             = regs.expected_table;
      s.len_hi          = 8'($urandom());
      s.len_hi[3:0]     = len[11:8];
      s.len_lo          = len[7:0];
      {s.ext_hi, s.ext_lo} = g_ext;
      s.ver_byte        = 8'($urandom());
      s.ver_byte[5:1]   = g_ver;
      s.ver_byte[0]     = 1'b1;
      s.last_idx        = g_last;
      if ($urandom_range(1)) begin
        s.sec_idx = g_next;
        g_next    = (g_next >= g_last) ? 8'd0 : g_next + 8'd1;
      end else begin
        s.sec_idx = 8'($urandom_range(g_last));
      end
      if (pick >= 70) begin
        case ($urandom_range(5))
          0: if (regs.min_header_bytes != 0)
               s.rx_bytes = LenW'($urandom_range(regs.min_header_bytes - 1));
          1: if (total - 1 >= regs.min_header_bytes) begin
               s.rx_bytes = LenW'(total - 1);
             end else begin
               s.len_hi[3:0] = 4'hf;
               s.len_lo      = 8'hff;
             end
          2: s.tid = s.tid ^ 8'($urandom_range(255, 1));
          3: s.ver_byte[0] = 1'b0;
          4: if (g_last < 255) s.sec_idx = 8'($urandom_range(255, g_last + 1));
          default: begin
            s.last_idx = 8'($urandom_range(255, MaxSections));
            s.sec_idx  = 8'($urandom_range(s.last_idx));
          end
        endcase
      end
    end else begin
      s = SectionW'({$urandom(), $urandom(), $urandom()});
      s.rx_bytes = LenW'(($urandom_range(9) == 0) ? $urandom_range(4098, 4090)
                                                  : $urandom_range(4098));
    end
    return s;
  endfunction

  task automatic send_section(input section_t s, input logic typed, input verdict_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid             = 1'b1;
    in_if.hdr_table_id      = s.tid;
    in_if.hdr_length_hi     = s.len_hi;
    in_if.hdr_length_lo     = s.len_lo;
    in_if.hdr_ext_hi        = s.ext_hi;
    in_if.hdr_ext_lo        = s.ext_lo;
    in_if.hdr_version_byte  = s.ver_byte;
    in_if.hdr_section_index = s.sec_idx;
    in_if.hdr_last_index    = s.last_idx;
    in_if.received_bytes    = s.rx_bytes;
    drv_typed               = typed;
    drv_verdict             = v;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_EXPECTED_TABLE: regs.expected_table     = value[7:0];
      REG_MIN_HEADER:     regs.min_header_bytes   = value[LenW-1:0];
      REG_MAX_SECTION:    regs.max_section_bytes  = value[LenW-1:0];
      REG_READ_LIMIT:     regs.read_attempt_limit = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic settle();
    in_if.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    verdict_t exp_v;
    verdict_t got_v;
    if (rst_ni && in_if.valid && in_if.ready) begin
      exp_v = track_section({in_if.hdr_table_id, in_if.hdr_length_hi, in_if.hdr_length_lo,
                             in_if.hdr_ext_hi, in_if.hdr_ext_lo, in_if.hdr_version_byte,
                             in_if.hdr_section_index, in_if.hdr_last_index,
                             in_if.received_bytes});
      if (drv_typed) exp_v = drv_verdict;
      pending_verdicts.push_back(exp_v);
      words_in++;
      if (exp_v.status == ST_STORED) stored_cnt++;
      if (exp_v.was_reset) resets_cnt++;
      if (exp_v.complete) complete_cnt++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_v = {out_if.status, out_if.table_was_reset, out_if.table_complete, out_if.read_budget};
      words_out++;
      if (pending_verdicts.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("Unexpected result word %0d: status %0d reset %0b complete %0b budget %0d",
                   words_out, got_v.status, got_v.was_reset, got_v.complete, got_v.budget);
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (got_v.status !== exp_v.status || got_v.was_reset !== exp_v.was_reset ||
            got_v.complete !== exp_v.complete || got_v.budget !== exp_v.budget) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("Result word %0d: expected status %0d reset %0b complete %0b budget %0d, %s",
                     words_out, exp_v.status, exp_v.was_reset, exp_v.complete, exp_v.budget,
                     $sformatf("got status %0d reset %0b complete %0b budget %0d",
                               got_v.status, got_v.was_reset, got_v.complete, got_v.budget));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog expired: %0d cycles without a transfer, %0d words outstanding",
               quiet_cycles, pending_verdicts.size());
      $display("** psi_section_table_tracker: FAILED **");
      $finish;
    end
  end

  initial begin
    row_t        dir_rows[$];
    section_t    s;
    logic [7:0]  t_id;
    logic [LenW-1:0] t_min;
    logic [LenW-1:0] t_max;
    logic [7:0]  t_lim;
    int unsigned phase;
    int unsigned k;

    rst_ni                  = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    in_if.valid             = 1'b0;
    in_if.hdr_table_id      = '0;
    in_if.hdr_length_hi     = '0;
    in_if.hdr_length_lo     = '0;
    in_if.hdr_ext_hi        = '0;
    in_if.hdr_ext_lo        = '0;
    in_if.hdr_version_byte  = '0;
    in_if.hdr_section_index = '0;
    in_if.hdr_last_index    = '0;
    in_if.received_bytes    = '0;
    drv_typed               = 1'b0;
    drv_verdict             = '0;
    send_idle_pct           = 0;
    recv_stall_pct          = 0;

    // Columns: table id, length hi/lo, extension hi/lo, version byte, section, last,
    // received bytes; then whether the verdict is typed, and the verdict.
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 13'd7,
                        1'b1, ST_SHORT, 1'b0, 1'b0, 8'd1});
    dir_rows.push_back({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 13'd0,
                        1'b1, ST_SHORT, 1'b0, 1'b0, 8'd1});
    dir_rows.push_back({8'h40, 8'h0f, 8'hff, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 13'd8,
                        1'b1, ST_BAD_LEN, 1'b0, 1'b0, 8'd1});
    dir_rows.push_back({8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 13'd4098,
                        1'b1, ST_BAD_LEN, 1'b0, 1'b0, 8'd1});
    dir_rows.push_back({8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 13'd8,
                        1'b1, ST_WRONG_TABLE, 1'b0, 1'b0, 8'd1});
    dir_rows.push_back({8'hff, 8'h00, 8'h05, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 13'd100,
                        1'b1, ST_WRONG_TABLE, 1'b0, 1'b0, 8'd1});
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'h00, 8'h00, 8'h3e, 8'h00, 8'h00, 13'd8,
                        1'b1, ST_NOT_CURRENT, 1'b0, 1'b0, 8'd1});
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'h00, 8'h00, 8'h01, 8'h05, 8'h04, 13'd8,
                        1'b1, ST_BAD_NUMBER, 1'b0, 1'b0, 8'd1});
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'h00, 8'h00, 8'h01, 8'h00, 8'h40, 13'd8,
                        1'b1, ST_BAD_NUMBER, 1'b0, 1'b0, 8'd1});
    dir_rows.push_back({8'h40, 8'h0f, 8'hf0, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 13'd4098,
                        1'b1, ST_BAD_NUMBER, 1'b0, 1'b0, 8'd1});
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'h12, 8'h34, 8'h03, 8'h00, 8'h00, 13'd8,
                        1'b1, ST_STORED, 1'b1, 1'b1, 8'd1});
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'h12, 8'h34, 8'h03, 8'h00, 8'h00, 13'd8,
                        1'b1, ST_STORED, 1'b0, 1'b1, 8'd1});
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'h12, 8'h34, 8'h03, 8'h01, 8'h02, 13'd30,
                        1'b1, ST_STORED, 1'b1, 1'b0, 8'd3});
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'h12, 8'h34, 8'h03, 8'h00, 8'h02, 13'd30,
                        1'b1, ST_STORED, 1'b0, 1'b0, 8'd3});
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'h12, 8'h34, 8'h03, 8'h02, 8'h02, 13'd30,
                        1'b1, ST_STORED, 1'b0, 1'b1, 8'd3});
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'h12, 8'h34, 8'h3f, 8'h00, 8'h02, 13'd30,
                        1'b1, ST_STORED, 1'b1, 1'b0, 8'd3});
    dir_rows.push_back({8'h40, 8'hf0, 8'h05, 8'hff, 8'hff, 8'h3f, 8'h3f, 8'h3f, 13'd8,
                        1'b1, ST_STORED, 1'b1, 1'b0, 8'd8});
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'hff, 8'hff, 8'h3f, 8'h3f, 8'h3f, 13'd7,
                        1'b1, ST_SHORT, 1'b0, 1'b0, 8'd8});
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'h00, 8'h00, 8'hc1, 8'h3e, 8'h3f, 13'd8,
                        1'b1, ST_STORED, 1'b1, 1'b0, 8'd8});
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'h00, 8'h00, 8'hc1, 8'h00, 8'h3f, 13'd8,
                        1'b0, 13'd0});
    dir_rows.push_back({8'h40, 8'h0f, 8'hfd, 8'h00, 8'h00, 8'hc1, 8'h01, 8'h3f, 13'd4096,
                        1'b0, 13'd0});
    dir_rows.push_back({8'h40, 8'h00, 8'h05, 8'h00, 8'h00, 8'hc1, 8'h40, 8'h3f, 13'd8,
                        1'b0, 13'd0});

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_section(dir_rows[i].hdr, dir_rows[i].typed, dir_rows[i].verdict);

    for (phase = 0; phase < NumPhases; phase++) begin
      settle();
      case (phase)
        0: begin
          t_id  = ExpectedTableRst;
          t_min = MinHeaderRst;
          t_max = MaxSectionRst;
          t_lim = ReadLimitRst;
        end
        1: begin
          t_id  = 8'd0;
          t_min = 13'd3;
          t_max = 13'd4098;
          t_lim = 8'd255;
        end
        2: begin
          t_id  = 8'd255;
          t_min = 13'd4098;
          t_max = 13'd3;
          t_lim = 8'd1;
        end
        3: begin
          // A zero attempt limit must still give a budget of one.
          t_id  = 8'h42;
          t_min = 13'd8;
          t_max = 13'd4098;
          t_lim = 8'd0;
        end
        default: begin
          t_id  = 8'($urandom_range(255));
          t_min = LenW'($urandom_range(40, 3));
          t_max = LenW'($urandom_range(4098, 40));
          t_lim = 8'($urandom_range(255, 1));
        end
      endcase
      write_reg(REG_EXPECTED_TABLE, DataW'(t_id));
      write_reg(REG_MIN_HEADER, DataW'(t_min));
      write_reg(REG_MAX_SECTION, DataW'(t_max));
      write_reg(REG_READ_LIMIT, DataW'(t_lim));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      pick_table_identity();
      for (k = 0; k < PhaseSections; k++) begin
        s = random_section();
        send_section(s, 1'b0, '0);
      end
    end

    in_if.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d section headers and checked %0d result words under %0d register settings.",
             words_in, words_out, NumPhases + 1);
    $display("Stored %0d, table resets %0d, complete reports %0d, mismatches %0d.",
             stored_cnt, resets_cnt, complete_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_verdicts.size() == 0) begin
      $display("** psi_section_table_tracker: PASSED **");
    end else begin
      $display("** psi_section_table_tracker: FAILED **");
    end
    $finish;
  end

endmodule

/* psi_section_table_tracker.f */
rtl/psitt_pkg.sv
rtl/psitt_if.sv
rtl/psitt_front.sv
rtl/psitt_queue.sv
rtl/psitt_back.sv
rtl/psi_section_table_tracker.sv
dv/tb.sv
